// File: hdl/hsi_pkg.sv
package hsi_pkg;

  localparam int NUM_SECTORS = 6;
  localparam int NUM_REFS    = 12;
  localparam int CODE_W      = 3;
  localparam int ANGLE_W     = 17;

  typedef logic [CODE_W-1:0]          code_t;
  typedef logic signed [ANGLE_W-1:0]  angle_t;
  typedef logic [NUM_SECTORS-1:0][CODE_W-1:0] slots_t;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_MATCH      = 2'd1,
    ST_NO_MATCH   = 2'd2
  } status_t;

  // update request from the input register to the slot store
  typedef struct packed {
    logic   en;
    logic   clear;
    code_t  code;
    angle_t angle;
  } upd_t;

  // open window bounds, 1/128 degree: (60k-1)*128 < angle < (60k+1)*128
  localparam angle_t WIN_LO [NUM_SECTORS] = '{
    -17'sd128, 17'sd7552, 17'sd15232, 17'sd22912, 17'sd30592, 17'sd38272
  };
  localparam angle_t WIN_HI [NUM_SECTORS] = '{
    17'sd128, 17'sd7808, 17'sd15488, 17'sd23168, 17'sd30848, 17'sd38528
  };

  // sector order 0, 60, 120, 180, 240, 300 degrees
  localparam code_t REF_TABLE [NUM_REFS][NUM_SECTORS] = '{
    '{3'd6, 3'd4, 3'd5, 3'd1, 3'd3, 3'd2},
    '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1},
    '{3'd6, 3'd2, 3'd3, 3'd1, 3'd5, 3'd4},
    '{3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4},
    '{3'd3, 3'd2, 3'd6, 3'd4, 3'd5, 3'd1},
    '{3'd3, 3'd1, 3'd5, 3'd4, 3'd6, 3'd2},
    '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5},
    '{3'd2, 3'd3, 3'd1, 3'd5, 3'd4, 3'd6},
    '{3'd1, 3'd5, 3'd4, 3'd6, 3'd2, 3'd3},
    '{3'd2, 3'd6, 3'd4, 3'd5, 3'd1, 3'd3},
    '{3'd4, 3'd5, 3'd1, 3'd3, 3'd2, 3'd6},
    '{3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5}
  };

endpackage

// File: hdl/hsi_sector_store.sv
module hsi_sector_store (
  input  logic          clk,
  input  logic          rst_n,
  input  hsi_pkg::upd_t upd,
  output hsi_pkg::slots_t slots_nxt
);
  import hsi_pkg::*;

  slots_t                 slots_r;
  logic [NUM_SECTORS-1:0] hit;

  always_comb begin
    for (int k = 0; k < NUM_SECTORS; k++) begin
      hit[k] = (upd.angle > WIN_LO[k]) && (upd.angle < WIN_HI[k]);
    end
  end

  always_comb begin
    slots_nxt = slots_r;
    if (upd.en) begin
      if (upd.clear) begin
        slots_nxt = '0;
      end else begin
        for (int k = 0; k < NUM_SECTORS; k++) begin
          if (hit[k]) begin
            slots_nxt[k] = upd.code;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= '0;
    end else begin
      slots_r <= slots_nxt;
    end
  end

`ifndef SYNTH
  a_windows_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    upd.en |-> $onehot0(hit))
    else $error("more than one sector window hit");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    upd.en && upd.clear |=> slots_r == '0)
    else $error("slots not empty after clear");

  a_miss_holds: assert property (@(posedge clk) disable iff (!rst_n)
    upd.en && !upd.clear && hit == '0 |=> $stable(slots_r))
    else $error("slot changed on a sample outside all windows");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !upd.en |=> $stable(slots_r))
    else $error("slot changed without an item");
`endif

endmodule

// File: hdl/hsi_matcher.sv
module hsi_matcher (
  input  hsi_pkg::slots_t  slots,
  output hsi_pkg::status_t status
);
  import hsi_pkg::*;

  logic                full;
  logic [NUM_REFS-1:0] row_eq;

  always_comb begin
    full = 1'b1;
    for (int k = 0; k < NUM_SECTORS; k++) begin
      if (slots[k] == '0) begin
        full = 1'b0;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_REFS; r++) begin
      row_eq[r] = 1'b1;
      for (int k = 0; k < NUM_SECTORS; k++) begin
        if (slots[k] != REF_TABLE[r][k]) begin
          row_eq[r] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (!full) begin
      status = ST_INCOMPLETE;
    end else if (|row_eq) begin
      status = ST_MATCH;
    end else begin
      status = ST_NO_MATCH;
    end
  end

endmodule

// File: hdl/hall_sequence_identifier.sv
// channel  dir  tdata (low bit up)                 tuser
// in_      in   hall_code[2:0], angle[19:3], 0 pad  mode (0 sample, 1 clear)
// out_     out  status[1:0], 0 pad                 -
//
// One item per cycle unless the result stalls; an accepted item passes stage 1, then the result register.
// Stage 1 is the input register; slot update, window decode and the twelve
// row compares sit between it and the result register.
// rst_n synchronous: empties all six slots and both stages.
// A stalled result holds the pipeline; stage 1 still fills if empty.
module hall_sequence_identifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // hall_code[2:0], angle[19:3], zero [23:20]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status[1:0], zero [7:2]
);
  import hsi_pkg::*;

  logic    s1_valid_r;
  logic    s1_mode_r;
  code_t   s1_code_r;
  angle_t  s1_angle_r;
  logic    out_valid_r;
  status_t out_status_r;

  logic    adv;
  logic    in_acc;
  upd_t    upd;
  slots_t  slots_nxt;
  status_t status_nxt;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign upd.en    = s1_valid_r && adv;
  assign upd.clear = s1_mode_r;
  assign upd.code  = s1_code_r;
  assign upd.angle = s1_angle_r;

  hsi_sector_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .slots_nxt (slots_nxt)
  );

  hsi_matcher u_match (
    .slots  (slots_nxt),
    .status (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r  <= in_tuser;
      s1_code_r  <= in_tdata[2:0];
      s1_angle_r <= in_tdata[19:3];
    end
    if (upd.en) begin
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r};

`ifndef SYNTH
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r)
    else $error("stage 1 item dropped while stalled");

  a_clear_status: assert property (@(posedge clk) disable iff (!rst_n)
    upd.en && s1_mode_r |=> out_status_r == ST_INCOMPLETE)
    else $error("clear item did not give incomplete");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !s1_valid_r |=> !out_valid_r)
    else $error("result appeared without an item in stage 1");
`endif

endmodule
